// ----- rtl/double_ended_queue_core_assert.svh -----
// Assertion macros used by the checker file of the deque core.
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque core assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque core assertion failed");

`endif

// ----- rtl/dq_pkg.sv -----
`timescale 1ns / 1ps
package dq_pkg;

    localparam int DEPTH  = 1024;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int OCC_W  = 11;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

    typedef struct packed {
        logic             pop_ok;
        status_t          status;
        logic [OCC_W-1:0] occupancy;
        logic             is_empty;
    } result_meta_t;

endpackage

// ----- rtl/dq_if.sv -----
`timescale 1ns / 1ps
interface dq_req_if;
    import dq_pkg::*;

    logic               valid;
    logic               ready;
    op_t                opcode;
    logic signed [31:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface

interface dq_rsp_if;
    import dq_pkg::*;

    logic                valid;
    logic                ready;
    logic signed [31:0]  popped_value;
    status_t             status;
    logic [OCC_W-1:0]    occupancy;
    logic                is_empty;

    modport source (output valid, output popped_value, output status, output occupancy,
                    output is_empty, input ready);
    modport sink (input valid, input popped_value, input status, input occupancy,
                  input is_empty, output ready);
endinterface

// ----- rtl/double_ended_queue_core.sv -----
`timescale 1ns / 1ps
// Channel   Role    Payload
// req       sink    opcode, value
// rsp       source  popped_value, status, occupancy, is_empty
//
// Each transaction on req yields one transaction on rsp in the following cycle.
// One transaction per cycle while rsp is ready; head, tail, count update at accept.
// A pop reads the word store through a registered read port into the output stage.
// A stalled rsp holds its result and blocks req until it is taken.
// Reset clears the indices and the count; the word store needs no clearing.
module double_ended_queue_core (
    input  logic     clk,
    input  logic     rst_n,
    dq_req_if.sink   req,
    dq_rsp_if.source rsp
);
    import dq_pkg::*;

    logic              accept;
    logic              rsp_valid_reg, rsp_valid_next;
    ram_req_t          ram_req;
    result_meta_t      meta;
    logic [WORD_W-1:0] rdata;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    dq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .opcode  (req.opcode),
        .value   (req.value),
        .ram_req (ram_req),
        .meta    (meta)
    );

    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        if (meta.pop_ok)
        begin
            rsp.popped_value = rdata;
        end
        else if (meta.status == ST_EMPTY)
        begin
            rsp.popped_value = '1;
        end
        else
        begin
            rsp.popped_value = '0;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = meta.status;
    assign rsp.occupancy = meta.occupancy;
    assign rsp.is_empty  = meta.is_empty;

endmodule

// ----- rtl/dq_ram.sv -----
`timescale 1ns / 1ps
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/dq_ctrl.sv -----
`timescale 1ns / 1ps
module dq_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  dq_pkg::op_t                  opcode,
    input  logic [dq_pkg::WORD_W-1:0]    value,
    output dq_pkg::ram_req_t             ram_req,
    output dq_pkg::result_meta_t         meta
);
    import dq_pkg::*;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    result_meta_t     meta_reg, meta_next;
    logic             full;
    logic             empty;

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
    endfunction

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        ram_req.we       = 1'b0;
        ram_req.waddr    = tail_reg;
        ram_req.wdata    = value;
        ram_req.re       = 1'b0;
        ram_req.raddr    = head_reg;
        meta_next.pop_ok = 1'b0;
        meta_next.status = ST_DONE;
        if (accept)
        begin
            unique case (opcode)
                OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        meta_next.status = ST_FULL;
                    end
                    else
                    begin
                        head_next     = idx_prev(head_reg);
                        ram_req.we    = 1'b1;
                        ram_req.waddr = idx_prev(head_reg);
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                OP_PUSH_REAR:
                begin
                    if (full)
                    begin
                        meta_next.status = ST_FULL;
                    end
                    else
                    begin
                        tail_next     = idx_next(tail_reg);
                        ram_req.we    = 1'b1;
                        ram_req.waddr = tail_reg;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        meta_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        head_next        = idx_next(head_reg);
                        ram_req.re       = 1'b1;
                        ram_req.raddr    = head_reg;
                        meta_next.pop_ok = 1'b1;
                        count_next       = count_reg - CNT_W'(1);
                    end
                end
                OP_POP_REAR:
                begin
                    if (empty)
                    begin
                        meta_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        tail_next        = idx_prev(tail_reg);
                        ram_req.re       = 1'b1;
                        ram_req.raddr    = idx_prev(tail_reg);
                        meta_next.pop_ok = 1'b1;
                        count_next       = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    meta_next.status = ST_DONE;
                end
            endcase
        end
        meta_next.occupancy = OCC_W'(count_next);
        meta_next.is_empty  = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            meta_reg <= meta_next;
        end
    end

    assign meta = meta_reg;

endmodule

// ----- rtl/dq_checker.sv -----
`timescale 1ns / 1ps
`include "double_ended_queue_core_assert.svh"
module dq_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [31:0]                rsp_popped_value,
    input dq_pkg::status_t            rsp_status,
    input logic [dq_pkg::OCC_W-1:0]   rsp_occupancy,
    input logic                       rsp_is_empty
);
    import dq_pkg::*;

    `DQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_popped_value) && $stable(rsp_status) && $stable(rsp_occupancy))
    `DQ_ASSERT_NEXT(a_result_follows, clk, rst_n, req_valid && req_ready, rsp_valid)
    `DQ_ASSERT_SAME(a_empty_flag, clk, rst_n, rsp_valid, rsp_is_empty == (rsp_occupancy == '0))
    `DQ_ASSERT_SAME(a_empty_pop, clk, rst_n, rsp_valid && rsp_status == ST_EMPTY, rsp_popped_value == '1 && rsp_is_empty)
    `DQ_ASSERT_SAME(a_full_push, clk, rst_n, rsp_valid && rsp_status == ST_FULL, rsp_popped_value == '0 && rsp_occupancy == OCC_W'(DEPTH))

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_popped_value (rsp.popped_value),
    .rsp_status       (rsp.status),
    .rsp_occupancy    (rsp.occupancy),
    .rsp_is_empty     (rsp.is_empty)
);
